@@ src/hall_key_rapid_trigger_top_defines.svh @@
// ---------------------------------------------------------------------------
// Hall key rapid trigger - assertion macros
// Concurrent assertion shorthands on clk; the first two take rst_n as the disable.
// ---------------------------------------------------------------------------
`ifndef HALL_KEY_RAPID_TRIGGER_TOP_DEFINES_SVH
`define HALL_KEY_RAPID_TRIGGER_TOP_DEFINES_SVH

// consequent checked in the same cycle, off during reset
`define HKRT_AST_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the next cycle, off during reset
`define HKRT_AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// consequent checked in the next cycle, live through reset
`define HKRT_AST_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/hkrt_pkg.sv @@
// ---------------------------------------------------------------------------
// hkrt_pkg - shared types and constants
// Widths, fixed-point format, per-channel state word and register indexes.
// ---------------------------------------------------------------------------
package hkrt_pkg;

  localparam int NUM_CHANNELS = 4;
  localparam int CH_W         = 2;
  localparam int FRAC_BITS    = 8;
  localparam int SAMPLE_W     = 12;
  localparam int LEVEL_W      = 12;
  localparam int LEVELS_W     = 48;
  localparam int ACC_W        = SAMPLE_W + FRAC_BITS;
  localparam int SMOOTH_W     = 7;
  localparam int PCT_W        = 7;
  localparam int SMOOTH_MAX   = 100;
  localparam int PCT_MAX      = 100;
  localparam int POL_W        = 4;
  localparam int CFG_IDX_W    = 3;

  // floor(2^32 / 100); estimate is exact or one low for numerators below 2^32
  localparam int RECIP_SHIFT  = 32;
  localparam int RECIP_W      = 26;
  localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'((64'd1 << RECIP_SHIFT) / 100);

  localparam logic [ACC_W-1:0] ACC_RST = ACC_W'(2500 << FRAC_BITS);

  localparam int IN_DATA_W    = ((SAMPLE_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = SAMPLE_W + PCT_W + 1;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int PCT_LSB      = SAMPLE_W;
  localparam int PRESSED_BIT  = SAMPLE_W + PCT_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REST     = 3'd0,
    CFG_ACTIVE   = 3'd1,
    CFG_TRIGGER  = 3'd2,
    CFG_SMOOTH   = 3'd3,
    CFG_POLARITY = 3'd4,
    CFG_RAPID_EN = 3'd5,
    CFG_SENS     = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [ACC_W-1:0] acc;
    logic [ACC_W-1:0] rev_point;
    logic             rising;
    logic             rapid_pressed;
  } state_word_t;

  localparam state_word_t STATE_RST = '{
    acc:           ACC_RST,
    rev_point:     '0,
    rising:        1'b0,
    rapid_pressed: 1'b0
  };

  typedef struct packed {
    logic            en;
    logic [CH_W-1:0] addr;
    state_word_t     data;
  } mem_wr_t;

endpackage

@@ src/hall_key_rapid_trigger_top.sv @@
// ---------------------------------------------------------------------------
// hall_key_rapid_trigger_top - Hall key smoothing and rapid trigger
// Per-channel moving average of ADC samples, travel percent and pressed
// flag from a fixed threshold or from rapid trigger.
// ---------------------------------------------------------------------------
//  Channel  Direction  Signals                         Contents
//  in       slave      in_tvalid/tready/tdata/tuser    sample / channel
//  out      master     out_tvalid/tready/tdata/tuser   value, pct, pressed / channel
//  cfg      write      cfg_wr_en/index/wdata           registers 0..6
//
//  One item at a time: the next sample is accepted only after the result has
//  moved into the output register. The divider (7 steps) runs only when the
//  percentage needs it, not when it clamps or is zero; the 4-stage average pipeline runs first.
//  State sits in a 4-entry memory; read on accept, written back with the result.
//  Reset is synchronous on rst_n; no clearing pass, unwritten entries read
//  as the reset state. A stalled result holds the block before write-back.
// ---------------------------------------------------------------------------
module hall_key_rapid_trigger_top import hkrt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [11:0] sample
  input  logic [CH_W-1:0]       in_tuser,   // [1:0] channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [11:0] smoothed_value, [18:12] travel_pct,
                                            // [19] pressed
  output logic [CH_W-1:0]       out_tuser,  // [1:0] out_channel
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [LEVELS_W-1:0]   cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EMA,
    S_EVAL,
    S_DIV,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [LEVELS_W-1:0] rest_r, active_r, trigger_r;
  logic [SMOOTH_W-1:0] smooth_r;
  logic [POL_W-1:0]    pol_r;
  logic                rapid_en_r;
  logic [LEVEL_W-1:0]  sens_r;

  // item context
  logic [CH_W-1:0]     ch_r;
  logic [SAMPLE_W-1:0] sample_r;
  state_word_t         word_n_r;
  logic                pressed_r;
  logic [SAMPLE_W-1:0] v_r;
  logic [PCT_W-1:0]    pct_fix_r;
  logic                use_div_r;

  logic                out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [CH_W-1:0]     out_user_r;

  logic                accept;
  logic                out_free;
  logic                finish;
  mem_wr_t             mem_wr;
  state_word_t         mem_rd;
  logic                ema_done;
  logic [ACC_W-1:0]    ema_acc;
  logic                div_start;
  logic                div_done;
  logic [PCT_W-1:0]    div_quot;

  // evaluation
  logic [SAMPLE_W-1:0]       v;
  logic [LEVEL_W-1:0]        lv_rest, lv_act, lv_trig;
  logic                      inv;
  logic signed [LEVEL_W:0]   span, delta, span_neg, delta_neg;
  logic [LEVEL_W-1:0]        span_mag, delta_mag;
  logic                      pct_pos, pct_full;
  logic                      up, flip, reach, to_press, to_release;
  logic [ACC_W-1:0]          rp_n, travel, thr;
  logic                      rp_eq_flag;
  state_word_t               word_n;
  logic                      pressed_n;
  logic [PCT_W-1:0]          pct_out;

  function automatic logic [LEVEL_W-1:0] level_of(input logic [LEVELS_W-1:0] p,
                                                  input logic [CH_W-1:0] ch);
    return p[ch * LEVEL_W +: LEVEL_W];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rest_r     <= '0;
      active_r   <= '0;
      trigger_r  <= '0;
      smooth_r   <= SMOOTH_W'(SMOOTH_MAX);
      pol_r      <= '0;
      rapid_en_r <= 1'b0;
      sens_r     <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_reg_e'(cfg_index))
        CFG_REST:     rest_r     <= cfg_wdata;
        CFG_ACTIVE:   active_r   <= cfg_wdata;
        CFG_TRIGGER:  trigger_r  <= cfg_wdata;
        CFG_SMOOTH:   smooth_r   <= cfg_wdata[SMOOTH_W-1:0];
        CFG_POLARITY: pol_r      <= cfg_wdata[POL_W-1:0];
        CFG_RAPID_EN: rapid_en_r <= cfg_wdata[0];
        CFG_SENS:     sens_r     <= cfg_wdata[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  assign accept   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign finish   = (state_r == S_DONE) && out_free;

  hkrt_state_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (mem_wr),
    .rd_en   (accept),
    .rd_addr (in_tuser),
    .rd_data (mem_rd)
  );

  hkrt_ema u_ema (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (state_r == S_READ),
    .smooth  (smooth_r),
    .sample  (sample_r),
    .acc_old (mem_rd.acc),
    .done    (ema_done),
    .acc_new (ema_acc)
  );

  hkrt_pct_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .num_mag (delta_mag),
    .den_mag (span_mag),
    .done    (div_done),
    .quot    (div_quot)
  );

  // --- travel percent setup ---
  assign v       = ema_acc[ACC_W-1:FRAC_BITS];
  assign lv_rest = level_of(rest_r, ch_r);
  assign lv_act  = level_of(active_r, ch_r);
  assign lv_trig = level_of(trigger_r, ch_r);
  assign inv     = pol_r[ch_r];

  always_comb begin
    if (inv) begin
      span  = $signed({1'b0, lv_rest}) - $signed({1'b0, lv_act});
      delta = $signed({1'b0, lv_rest}) - $signed({1'b0, v});
    end else begin
      span  = $signed({1'b0, lv_act}) - $signed({1'b0, lv_rest});
      delta = $signed({1'b0, v}) - $signed({1'b0, lv_rest});
    end
  end

  assign span_neg  = -span;
  assign delta_neg = -delta;
  assign span_mag  = span[LEVEL_W] ? span_neg[LEVEL_W-1:0] : span[LEVEL_W-1:0];
  assign delta_mag = delta[LEVEL_W] ? delta_neg[LEVEL_W-1:0] : delta[LEVEL_W-1:0];
  // positive quotient only when delta and span share a sign; equal levels give zero
  assign pct_pos   = (!delta[LEVEL_W] && (delta != '0) && !span[LEVEL_W] && (span != '0))
                  || (delta[LEVEL_W] && span[LEVEL_W]);
  assign pct_full  = delta_mag >= span_mag;
  assign div_start = (state_r == S_EVAL) && pct_pos && !pct_full;

  // --- pressed decision ---
  assign up         = ema_acc > mem_rd.rev_point;
  assign rp_eq_flag = up == mem_rd.rising;
  assign flip       = !rp_eq_flag;
  assign rp_n       = flip ? ema_acc : mem_rd.rev_point;
  assign travel     = (ema_acc >= rp_n) ? (ema_acc - rp_n) : (rp_n - ema_acc);
  assign thr        = {sens_r, {FRAC_BITS{1'b0}}};
  assign reach      = travel >= thr;
  assign to_press   = inv ? !up : up;
  assign to_release = inv ? up : !up;

  always_comb begin
    word_n     = mem_rd;
    word_n.acc = ema_acc;
    if (rapid_en_r) begin
      word_n.rising    = up;
      word_n.rev_point = rp_n;
      if (!mem_rd.rapid_pressed) begin
        word_n.rapid_pressed = to_press && reach;
      end else begin
        word_n.rapid_pressed = !(to_release && reach);
      end
      pressed_n = word_n.rapid_pressed;
    end else begin
      pressed_n = inv ? (v < lv_trig) : (v > lv_trig);
    end
  end

  // capture item and evaluation results
  always_ff @(posedge clk) begin
    if (accept) begin
      ch_r     <= in_tuser;
      sample_r <= in_tdata[SAMPLE_W-1:0];
    end
    if (state_r == S_EVAL) begin
      word_n_r  <= word_n;
      pressed_r <= pressed_n;
      v_r       <= v;
      pct_fix_r <= pct_pos ? PCT_W'(PCT_MAX) : '0;
      use_div_r <= pct_pos && !pct_full;
    end
  end

  assign pct_out = use_div_r ? div_quot : pct_fix_r;

  always_comb begin
    mem_wr.en   = finish;
    mem_wr.addr = ch_r;
    mem_wr.data = word_n_r;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_tvalid) state_nxt = S_READ;
      S_READ:  state_nxt = S_EMA;
      S_EMA:   if (ema_done) state_nxt = S_EVAL;
      S_EVAL:  state_nxt = div_start ? S_DIV : S_DONE;
      S_DIV:   if (div_done) state_nxt = S_DONE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (finish) begin
        out_valid_r <= 1'b1;
        out_user_r  <= ch_r;
        out_data_r  <= OUT_DATA_W'({pressed_r, pct_out, v_r});
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

@@ src/hkrt_state_mem.sv @@
// ---------------------------------------------------------------------------
// hkrt_state_mem - per-channel state memory
// One write port, one read port, registered read data; entries never
// written read back as the reset state word.
// ---------------------------------------------------------------------------
module hkrt_state_mem import hkrt_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  mem_wr_t         wr,
  input  logic            rd_en,
  input  logic [CH_W-1:0] rd_addr,
  output state_word_t     rd_data
);

  state_word_t               mem [NUM_CHANNELS];
  state_word_t               rd_q_r;
  logic [NUM_CHANNELS-1:0]   vld_r;
  logic                      rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr.en) begin
        vld_r[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : STATE_RST;

endmodule

@@ src/hkrt_ema.sv @@
// ---------------------------------------------------------------------------
// hkrt_ema - moving average update
// Four-stage pipeline: weight products, sum, reciprocal estimate of the
// divide by 100, remainder correction.
// ---------------------------------------------------------------------------
module hkrt_ema import hkrt_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [SMOOTH_W-1:0] smooth,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic [ACC_W-1:0]    acc_old,
  output logic                done,
  output logic [ACC_W-1:0]    acc_new
);

  localparam int NUM_W  = ACC_W + SMOOTH_W;
  localparam int PROD_W = NUM_W + RECIP_W;

  logic [SMOOTH_W-1:0] s_w;
  logic [SMOOTH_W-1:0] s_c;
  logic [NUM_W-1:0]    p_new_r;
  logic [NUM_W-1:0]    p_old_r;
  logic [NUM_W-1:0]    sum_r;
  logic [NUM_W-1:0]    sum2_r;
  logic [PROD_W-1:0]   prod;
  logic [ACC_W-1:0]    q_est_r;
  logic [NUM_W-1:0]    rem;
  logic [ACC_W-1:0]    acc_r;
  logic [3:0]          vld_r;

  // weights above 100 act as 100
  assign s_w = (smooth > SMOOTH_W'(SMOOTH_MAX)) ? SMOOTH_W'(SMOOTH_MAX) : smooth;
  assign s_c = SMOOTH_W'(SMOOTH_MAX) - s_w;

  assign prod = PROD_W'(sum_r) * PROD_W'(RECIP_100);
  assign rem  = sum2_r - NUM_W'(q_est_r) * NUM_W'(100);

  always_ff @(posedge clk) begin
    p_new_r <= NUM_W'(s_w) * NUM_W'({sample, {FRAC_BITS{1'b0}}});
    p_old_r <= NUM_W'(s_c) * NUM_W'(acc_old);
    sum_r   <= p_new_r + p_old_r;
    sum2_r  <= sum_r;
    q_est_r <= prod[RECIP_SHIFT +: ACC_W];
    // estimate is at most one low
    acc_r   <= q_est_r + ACC_W'(rem >= NUM_W'(100));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], start};
    end
  end

  assign done    = vld_r[3];
  assign acc_new = acc_r;

endmodule

@@ src/hkrt_pct_div.sv @@
// ---------------------------------------------------------------------------
// hkrt_pct_div - travel percentage divider
// Restoring divide of |delta| * 100 by |span|, one quotient bit a cycle.
// Only used when |delta| < |span|, so the quotient fits below 128.
// ---------------------------------------------------------------------------
module hkrt_pct_div import hkrt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [LEVEL_W-1:0] num_mag,
  input  logic [LEVEL_W-1:0] den_mag,
  output logic               done,
  output logic [PCT_W-1:0]   quot
);

  localparam int REM_W = LEVEL_W + PCT_W;
  localparam int CNT_W = $clog2(PCT_W + 1);

  logic [REM_W-1:0] rem_r;
  logic [REM_W-1:0] dsr_r;
  logic [PCT_W-1:0] q_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic             ge;

  assign ge = rem_r >= dsr_r;

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= REM_W'(num_mag) * REM_W'(PCT_MAX);
      dsr_r <= REM_W'({den_mag, {(PCT_W-1){1'b0}}});
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - dsr_r;
      end
      dsr_r <= dsr_r >> 1;
      q_r   <= {q_r[PCT_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(PCT_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

@@ src/hkrt_port_checker.sv @@
// ---------------------------------------------------------------------------
// hkrt_port_checker - port-level checks for the Hall key block
// Watches the stream ports only; bound to the top level below.
// ---------------------------------------------------------------------------
`include "hall_key_rapid_trigger_top_defines.svh"

module hkrt_port_checker import hkrt_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [CH_W-1:0]       out_tuser
);

  // a held result keeps its contents
  `HKRT_AST_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "out item changed while stalled")

  // one item in flight: no accept right after an accept
  `HKRT_AST_NEXT(a_one_item, in_tvalid && in_tready, !in_tready, "input taken while an item is in work")

  // percentage stays clamped and padding stays zero
  `HKRT_AST_SAME(a_pct_range, out_tvalid, (out_tdata[PCT_LSB +: PCT_W] <= PCT_W'(PCT_MAX)) && (out_tdata[OUT_DATA_W-1:PRESSED_BIT+1] == '0), "travel percent out of range")

  // reset drops any pending result
  `HKRT_AST_RST(a_rst_clear, !rst_n, !out_tvalid, "result valid after reset")

endmodule

bind hall_key_rapid_trigger_top hkrt_port_checker u_port_checker (.*);

@@ dv/key_report_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// key_report_checker - predictor and scoreboard for the Hall key block
// Snoops register writes and accepted samples, keeps its own per-channel
// average and rapid trigger state, and compares every accepted report with
// the oldest predicted one.
// ---------------------------------------------------------------------------
module key_report_checker import hkrt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [11:0] sample
  input  logic [CH_W-1:0]       in_tuser,   // [1:0] channel
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,  // [11:0] smoothed_value, [18:12] travel_pct,
                                            // [19] pressed
  input  logic [CH_W-1:0]       out_tuser,  // [1:0] out_channel
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [LEVELS_W-1:0]   cfg_wdata,
  output int unsigned           fail_count,
  output int unsigned           reports_pending
);

  typedef struct packed {
    logic [CH_W-1:0]     ch;
    logic [SAMPLE_W-1:0] value;
    logic [PCT_W-1:0]    pct;
    logic                pressed;
  } key_report_t;

  logic [LEVELS_W-1:0] rest_word;
  logic [LEVELS_W-1:0] active_word;
  logic [LEVELS_W-1:0] trigger_word;
  logic [SMOOTH_W-1:0] smooth_pct;
  logic [POL_W-1:0]    pol_mask;
  logic                rapid_on;
  logic [LEVEL_W-1:0]  rapid_sens;

  logic [ACC_W-1:0]    avg_acc    [NUM_CHANNELS];
  logic [ACC_W-1:0]    turn_acc   [NUM_CHANNELS];
  logic                rising_dir [NUM_CHANNELS];
  logic                rt_pressed [NUM_CHANNELS];

  key_report_t         expected_reports [$];
  int unsigned         errs = 0;

  function automatic logic [LEVEL_W-1:0] level_at(logic [LEVELS_W-1:0] word,
                                                  logic [CH_W-1:0] ch);
    return word[LEVEL_W*ch +: LEVEL_W];
  endfunction

  // Advance one channel's average and trigger state, return the report it gives
  function automatic key_report_t predict_report(logic [CH_W-1:0] ch,
                                                 logic [SAMPLE_W-1:0] smp);
    key_report_t        rep;
    logic [63:0]        wt;
    logic [63:0]        mix;
    logic [ACC_W-1:0]   acc_n;
    logic [ACC_W-1:0]   moved;
    logic [ACC_W-1:0]   thr;
    logic [LEVEL_W-1:0] v;
    logic               inv;
    logic               up;
    longint             v_i;
    longint             r_lv;
    longint             a_lv;
    longint             span;
    longint             delta;
    longint             pct;
    wt    = (smooth_pct > SMOOTH_MAX) ? 64'(SMOOTH_MAX) : 64'(smooth_pct);
    mix   = wt * (64'(smp) << FRAC_BITS) + (64'(SMOOTH_MAX) - wt) * 64'(avg_acc[ch]);
    acc_n = ACC_W'(mix / 64'(SMOOTH_MAX));
    avg_acc[ch] = acc_n;
    v   = acc_n[ACC_W-1:FRAC_BITS];
    inv = pol_mask[ch];
    if (!rapid_on) begin
      rep.pressed = inv ? (v < level_at(trigger_word, ch)) : (v > level_at(trigger_word, ch));
    end else begin
      up = acc_n > turn_acc[ch];
      // move the reference only on a change of direction
      if (up != rising_dir[ch]) begin
        rising_dir[ch] = up;
        turn_acc[ch]   = acc_n;
      end
      moved = (acc_n >= turn_acc[ch]) ? acc_n - turn_acc[ch] : turn_acc[ch] - acc_n;
      thr   = {rapid_sens, {FRAC_BITS{1'b0}}};
      if (!rt_pressed[ch]) begin
        if ((inv ? !up : up) && moved >= thr) rt_pressed[ch] = 1'b1;
      end else if ((inv ? up : !up) && moved >= thr) begin
        rt_pressed[ch] = 1'b0;
      end
      rep.pressed = rt_pressed[ch];
    end
    v_i  = longint'(v);
    r_lv = longint'(level_at(rest_word, ch));
    a_lv = longint'(level_at(active_word, ch));
    if (a_lv == r_lv) begin
      pct = 0;
    end else begin
      span  = inv ? r_lv - a_lv : a_lv - r_lv;
      delta = inv ? r_lv - v_i : v_i - r_lv;
      pct   = (delta * PCT_MAX) / span;
      if (pct < 0) pct = 0;
      if (pct > PCT_MAX) pct = PCT_MAX;
    end
    rep.ch    = ch;
    rep.value = v;
    rep.pct   = PCT_W'(pct);
    return rep;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    key_report_t want;
    if (!rst_n) begin
      rest_word    = '0;
      active_word  = '0;
      trigger_word = '0;
      smooth_pct   = SMOOTH_W'(SMOOTH_MAX);
      pol_mask     = '0;
      rapid_on     = 1'b0;
      rapid_sens   = '0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        avg_acc[c]    = ACC_RST;
        turn_acc[c]   = '0;
        rising_dir[c] = 1'b0;
        rt_pressed[c] = 1'b0;
      end
      expected_reports.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_REST:     rest_word    = cfg_wdata;
          CFG_ACTIVE:   active_word  = cfg_wdata;
          CFG_TRIGGER:  trigger_word = cfg_wdata;
          CFG_SMOOTH:   smooth_pct   = cfg_wdata[SMOOTH_W-1:0];
          CFG_POLARITY: pol_mask     = cfg_wdata[POL_W-1:0];
          CFG_RAPID_EN: rapid_on     = cfg_wdata[0];
          CFG_SENS:     rapid_sens   = cfg_wdata[LEVEL_W-1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (expected_reports.size() == 0) begin
          $error("report for channel %0d with no sample pending", out_tuser);
          errs++;
        end else begin
          want = expected_reports.pop_front();
          check_field("out_channel", 32'(want.ch), 32'(out_tuser));
          check_field("smoothed_value", 32'(want.value), 32'(out_tdata[SAMPLE_W-1:0]));
          check_field("travel_pct", 32'(want.pct), 32'(out_tdata[PCT_LSB +: PCT_W]));
          check_field("pressed", 32'(want.pressed), 32'(out_tdata[PRESSED_BIT]));
        end
      end
      if (in_tvalid && in_tready) begin
        expected_reports.push_back(predict_report(in_tuser, in_tdata[SAMPLE_W-1:0]));
      end
    end
    fail_count      <= errs;
    reports_pending <= expected_reports.size();
  end

endmodule

@@ dv/tb_hall_key_rapid_trigger_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_hall_key_rapid_trigger_top - testbench for the Hall key block
// Directed samples at the level extremes and special cases, then phases of
// random settings with key strokes and noise, some under sender and receiver gaps.
// ---------------------------------------------------------------------------
module tb_hall_key_rapid_trigger_top;
  import hkrt_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS   = 75;
  localparam int TAIL_CYCLES   = 40;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [CH_W-1:0]       in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [CH_W-1:0]       out_tuser;
  logic                  cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [LEVELS_W-1:0]   cfg_wdata  = '0;
  int unsigned           fail_count;
  int unsigned           reports_pending;

  int                    idle_pct   = 0;
  int                    stall_pct  = 0;
  logic [LEVELS_W-1:0]   rest_word   = '0;
  logic [LEVELS_W-1:0]   active_word = '0;
  logic                  toward_press [NUM_CHANNELS] = '{default: 1'b1};

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  hall_key_rapid_trigger_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  key_report_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .reports_pending (reports_pending)
  );

  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  function automatic logic [LEVELS_W-1:0] pack_levels(logic [LEVEL_W-1:0] l0,
                                                      logic [LEVEL_W-1:0] l1,
                                                      logic [LEVEL_W-1:0] l2,
                                                      logic [LEVEL_W-1:0] l3);
    return {l3, l2, l1, l0};
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEVELS_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == CFG_REST) rest_word = val;
    if (idx == CFG_ACTIVE) active_word = val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_sample(input logic [CH_W-1:0] ch, input logic [SAMPLE_W-1:0] smp);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_W'(smp);
    in_tuser  <= ch;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Hold off the sender until every report is back
  task automatic drain();
    in_tvalid <= 1'b0;
    while (reports_pending != 0) @(negedge clk);
  endtask

  // Travel from one level toward the other with some jitter on the samples
  task automatic key_stroke(input logic [CH_W-1:0] ch, output int cnt);
    int r_lv;
    int a_lv;
    int start;
    int stop;
    int steps;
    int val;
    r_lv  = int'(rest_word[LEVEL_W*ch +: LEVEL_W]);
    a_lv  = int'(active_word[LEVEL_W*ch +: LEVEL_W]);
    start = toward_press[ch] ? r_lv : a_lv;
    stop  = toward_press[ch] ? a_lv : r_lv;
    stop  = start + (stop - start) * int'($urandom_range(40, 100)) / 100;
    steps = $urandom_range(3, 10);
    for (int k = 1; k <= steps; k++) begin
      val = start + (stop - start) * k / steps + int'($urandom_range(0, 30)) - 15;
      if (val < 0) val = 0;
      if (val > 4095) val = 4095;
      send_sample(ch, SAMPLE_W'(val));
    end
    toward_press[ch] = !toward_press[ch];
    cnt = steps;
  endtask

  task automatic pick_setup(input int p);
    logic [LEVEL_W-1:0] r_lv [NUM_CHANNELS];
    logic [LEVEL_W-1:0] a_lv [NUM_CHANNELS];
    logic [LEVEL_W-1:0] t_lv [NUM_CHANNELS];
    logic [POL_W-1:0]   pol;
    logic [LEVELS_W-1:0] rw;
    logic [LEVELS_W-1:0] aw;
    logic [LEVELS_W-1:0] tw;
    int lo;
    int hi;
    int kind;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      pol[c] = (p == 1) ? 1'b1 : (p == 0) ? 1'b0 : 1'($urandom_range(0, 1));
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        lo = $urandom_range(0, 4095);
        hi = lo;
      end else if (kind == 1) begin
        lo = 0;
        hi = 4095;
      end else begin
        lo = $urandom_range(100, 1500);
        hi = $urandom_range(2500, 4000);
      end
      t_lv[c] = LEVEL_W'(lo + int'($urandom_range(0, hi - lo)));
      // mostly match the level order to the polarity, sometimes not
      if (pol[c] ^ (kind == 2)) begin
        r_lv[c] = LEVEL_W'(hi);
        a_lv[c] = LEVEL_W'(lo);
      end else begin
        r_lv[c] = LEVEL_W'(lo);
        a_lv[c] = LEVEL_W'(hi);
      end
    end
    rw = pack_levels(r_lv[0], r_lv[1], r_lv[2], r_lv[3]);
    aw = pack_levels(a_lv[0], a_lv[1], a_lv[2], a_lv[3]);
    tw = pack_levels(t_lv[0], t_lv[1], t_lv[2], t_lv[3]);
    if (p == 3 || $urandom_range(0, 5) == 0) begin
      rw = LEVELS_W'({$urandom, $urandom});
      aw = LEVELS_W'({$urandom, $urandom});
      tw = LEVELS_W'({$urandom, $urandom});
    end
    write_reg(CFG_REST, rw);
    write_reg(CFG_ACTIVE, aw);
    write_reg(CFG_TRIGGER, tw);
    case ($urandom_range(0, 7))
      0:       write_reg(CFG_SMOOTH, LEVELS_W'(SMOOTH_MAX));
      1:       write_reg(CFG_SMOOTH, LEVELS_W'($urandom_range(101, 127)));
      2:       write_reg(CFG_SMOOTH, LEVELS_W'($urandom_range(0, 10)));
      default: write_reg(CFG_SMOOTH, LEVELS_W'($urandom_range(15, 100)));
    endcase
    write_reg(CFG_POLARITY, LEVELS_W'(pol));
    write_reg(CFG_RAPID_EN, LEVELS_W'(p % 3 != 0));
    case ($urandom_range(0, 7))
      0:       write_reg(CFG_SENS, 0);
      1:       write_reg(CFG_SENS, 4095);
      default: write_reg(CFG_SENS, LEVELS_W'($urandom_range(1, 250)));
    endcase
  endtask

  initial begin
    int n;
    int cnt;
    bit paused;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // level extremes, inverted channel, equal levels, unreachable threshold
    write_reg(CFG_REST, pack_levels(200, 3800, 2000, 0));
    write_reg(CFG_ACTIVE, pack_levels(3800, 200, 2000, 4095));
    write_reg(CFG_TRIGGER, pack_levels(2000, 2000, 2000, 4095));
    write_reg(CFG_POLARITY, LEVELS_W'(4'b0010));
    write_reg(CFG_SMOOTH, LEVELS_W'(SMOOTH_MAX));
    write_reg(CFG_RAPID_EN, 0);
    write_reg(CFG_SENS, 0);
    send_sample(0, 0);
    send_sample(0, 4095);
    send_sample(1, 0);
    send_sample(1, 4095);
    send_sample(2, 0);
    send_sample(2, 4095);
    send_sample(3, 4095);
    send_sample(3, 0);
    send_sample(0, 2000);
    drain();
    // weight above the top of the range, then a frozen average
    write_reg(CFG_SMOOTH, 127);
    send_sample(0, 1234);
    send_sample(1, 4095);
    drain();
    write_reg(CFG_SMOOTH, 0);
    send_sample(0, 4095);
    drain();
    write_reg(CFG_SMOOTH, 50);
    send_sample(3, 4095);
    drain();
    // a write past the last register must change nothing
    write_reg(CFG_SPARE, '1);
    send_sample(3, 4095);
    drain();
    write_reg(CFG_SMOOTH, LEVELS_W'(SMOOTH_MAX));
    write_reg(CFG_RAPID_EN, 1);
    write_reg(CFG_SENS, 100);
    send_sample(0, 1000);
    send_sample(0, 1050);
    send_sample(0, 1200);
    send_sample(0, 1150);
    send_sample(0, 1050);
    send_sample(1, 2800);
    drain();
    write_reg(CFG_SENS, 0);
    write_reg(CFG_POLARITY, LEVELS_W'(4'hF));
    send_sample(2, 500);
    send_sample(2, 500);
    drain();
    write_reg(CFG_SENS, 4095);
    send_sample(3, 4095);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      pick_setup(p);
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 47; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 47; end
        default: begin idle_pct = 10; stall_pct = 10; end
      endcase
      n = 0;
      paused = 1'b0;
      while (n < PHASE_ITEMS) begin
        if ($urandom_range(0, 3) != 0) begin
          key_stroke(CH_W'($urandom_range(0, NUM_CHANNELS - 1)), cnt);
          n += cnt;
        end else begin
          send_sample(CH_W'($urandom_range(0, 3)), SAMPLE_W'($urandom_range(0, 4095)));
          n++;
        end
        if (p == 2 && !paused && n >= PHASE_ITEMS / 2) begin
          drain();
          paused = 1'b1;
        end
      end
      drain();
    end

    idle_pct  = 0;
    stall_pct = 0;
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0 && reports_pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

@@ hall_key_rapid_trigger_top.f @@
+incdir+src
src/hkrt_pkg.sv
src/hkrt_state_mem.sv
src/hkrt_ema.sv
src/hkrt_pct_div.sv
src/hall_key_rapid_trigger_top.sv
src/hkrt_port_checker.sv
dv/key_report_checker.sv
dv/tb_hall_key_rapid_trigger_top.sv
